// ===== rtl/core/lpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpw_pkg
// Shared types and constants for the leader progress watchdog.
// ----------------------------------------------------------------------------
package lpw_pkg;

    localparam int GEN_W   = 32;
    localparam int TAG_W   = 16;
    localparam int CODE_W  = 3;
    localparam int OP_W    = 3;
    localparam int TICKS_W = 32;
    localparam int COUNT_W = TICKS_W + 1;
    localparam int MASK_W  = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICKS_W-1:0] GRACE_RESET    = 32'd1000;
    localparam logic [TICKS_W-1:0] PROGRESS_RESET = 32'd1000;
    localparam logic [MASK_W-1:0]  MASK_RESET     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRACE_TICKS    = 2'd0,
        CFG_PROGRESS_TICKS = 2'd1,
        CFG_EVENT_MASK     = 2'd2
    } cfg_index_t;

    typedef enum logic [OP_W-1:0] {
        OP_ACTIVATE = 3'd0,
        OP_PROGRESS = 3'd1,
        OP_GRANT    = 3'd2,
        OP_TICK     = 3'd3,
        OP_SHUTDOWN = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        PH_INACTIVE = 4'b0001,
        PH_GRACE    = 4'b0010,
        PH_PROGRESS = 4'b0100,
        PH_EXPIRED  = 4'b1000
    } phase_t;

    localparam logic [1:0] PH_CODE_INACTIVE = 2'd0;
    localparam logic [1:0] PH_CODE_GRACE    = 2'd1;
    localparam logic [1:0] PH_CODE_PROGRESS = 2'd2;
    localparam logic [1:0] PH_CODE_EXPIRED  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [GEN_W-1:0]  view_gen;
        logic [TAG_W-1:0]  view_tag;
        logic [CODE_W-1:0] event_code;
    } item_t;

    typedef struct packed {
        logic              accepted;
        logic              rotate;
        logic [1:0]        phase_now;
        logic              active_valid;
        logic [GEN_W-1:0]  active_generation;
        logic [TAG_W-1:0]  active_tag;
    } result_t;

    typedef struct packed {
        logic [TICKS_W-1:0] grace_ticks;
        logic [TICKS_W-1:0] progress_ticks;
        logic [MASK_W-1:0]  event_mask;
    } cfg_t;

endpackage

// ===== rtl/core/lpw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpw_engine
// Watchdog state and the combinational step that applies one request to it.
// ----------------------------------------------------------------------------
module lpw_engine
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  lpw_pkg::item_t  item,
    input  lpw_pkg::cfg_t   cfg,
    output lpw_pkg::result_t res
);

    logic                         stopped_reg, stopped_next;
    lpw_pkg::phase_t              phase_reg, phase_next;
    logic                         view_valid_reg, view_valid_next;
    logic [lpw_pkg::GEN_W-1:0]    view_gen_reg, view_gen_next;
    logic [lpw_pkg::TAG_W-1:0]    view_tag_reg, view_tag_next;
    logic [lpw_pkg::GEN_W-1:0]    last_gen_reg, last_gen_next;
    logic [lpw_pkg::COUNT_W-1:0]  remaining_reg, remaining_next;
    logic                         granted_reg, granted_next;

    logic                         names_active;
    logic                         mask_hit;
    logic                         in_window;
    logic [lpw_pkg::COUNT_W-1:0]  count_dec;
    logic                         acc;
    logic                         rot;

    assign names_active = view_valid_reg && (view_gen_reg == item.view_gen)
                          && (view_tag_reg == item.view_tag);
    assign mask_hit  = cfg.event_mask[item.event_code];
    assign in_window = (phase_reg == lpw_pkg::PH_GRACE)
                       || (phase_reg == lpw_pkg::PH_PROGRESS);
    // A count already at zero stays there, so the next tick fires.
    assign count_dec = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;

    always_comb
    begin
        stopped_next    = stopped_reg;
        phase_next      = phase_reg;
        view_valid_next = view_valid_reg;
        view_gen_next   = view_gen_reg;
        view_tag_next   = view_tag_reg;
        last_gen_next   = last_gen_reg;
        remaining_next  = remaining_reg;
        granted_next    = granted_reg;
        acc             = 1'b0;
        rot             = 1'b0;

        if (!stopped_reg)
        begin
            unique case (item.operation)
                lpw_pkg::OP_ACTIVATE:
                begin
                    if ((item.view_gen != '0) &&
                        (item.view_gen > last_gen_reg))
                    begin
                        last_gen_next   = item.view_gen;
                        view_valid_next = 1'b1;
                        view_gen_next   = item.view_gen;
                        view_tag_next   = item.view_tag;
                        phase_next      = lpw_pkg::PH_GRACE;
                        remaining_next  = {1'b0, cfg.grace_ticks};
                        granted_next    = 1'b0;
                        acc             = 1'b1;
                    end
                end
                lpw_pkg::OP_PROGRESS:
                begin
                    if (names_active && mask_hit)
                    begin
                        if (phase_reg == lpw_pkg::PH_GRACE)
                        begin
                            acc = 1'b1;
                        end
                        else if (phase_reg == lpw_pkg::PH_PROGRESS)
                        begin
                            remaining_next = {1'b0, cfg.progress_ticks};
                            acc            = 1'b1;
                        end
                    end
                end
                lpw_pkg::OP_GRANT:
                begin
                    if (names_active && !granted_reg && in_window)
                    begin
                        remaining_next = {cfg.progress_ticks, 1'b0};
                        phase_next     = lpw_pkg::PH_PROGRESS;
                        granted_next   = 1'b1;
                        acc            = 1'b1;
                    end
                end
                lpw_pkg::OP_TICK:
                begin
                    if (in_window)
                    begin
                        remaining_next = count_dec;
                        if (count_dec == '0)
                        begin
                            acc = 1'b1;
                            if (phase_reg == lpw_pkg::PH_GRACE)
                            begin
                                phase_next     = lpw_pkg::PH_PROGRESS;
                                remaining_next = {1'b0, cfg.progress_ticks};
                            end
                            else
                            begin
                                phase_next = lpw_pkg::PH_EXPIRED;
                                rot        = 1'b1;
                            end
                        end
                    end
                end
                lpw_pkg::OP_SHUTDOWN:
                begin
                    stopped_next    = 1'b1;
                    view_valid_next = 1'b0;
                    view_gen_next   = '0;
                    view_tag_next   = '0;
                    phase_next      = lpw_pkg::PH_INACTIVE;
                    remaining_next  = '0;
                    acc             = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.accepted = acc;
        res.rotate   = rot;
        unique case (phase_next)
            lpw_pkg::PH_GRACE:    res.phase_now = lpw_pkg::PH_CODE_GRACE;
            lpw_pkg::PH_PROGRESS: res.phase_now = lpw_pkg::PH_CODE_PROGRESS;
            lpw_pkg::PH_EXPIRED:  res.phase_now = lpw_pkg::PH_CODE_EXPIRED;
            default:              res.phase_now = lpw_pkg::PH_CODE_INACTIVE;
        endcase
        if (stopped_next)
        begin
            res.phase_now = lpw_pkg::PH_CODE_INACTIVE;
        end
        res.active_valid      = view_valid_next && !stopped_next;
        res.active_generation = res.active_valid ? view_gen_next : '0;
        res.active_tag        = res.active_valid ? view_tag_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg    <= 1'b0;
            phase_reg      <= lpw_pkg::PH_INACTIVE;
            view_valid_reg <= 1'b0;
            view_gen_reg   <= '0;
            view_tag_reg   <= '0;
            last_gen_reg   <= '0;
            remaining_reg  <= '0;
            granted_reg    <= 1'b0;
        end
        else if (fire)
        begin
            stopped_reg    <= stopped_next;
            phase_reg      <= phase_next;
            view_valid_reg <= view_valid_next;
            view_gen_reg   <= view_gen_next;
            view_tag_reg   <= view_tag_next;
            last_gen_reg   <= last_gen_next;
            remaining_reg  <= remaining_next;
            granted_reg    <= granted_next;
        end
    end

endmodule

// ===== rtl/core/leader_progress_watchdog.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leader_progress_watchdog
// Phased watchdog (inactive, grace, progress, expired) over the active view.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (in_valid / in_stall) as one beat
//   each: operation, view_gen, view_tag, event_code. Every request
//   yields exactly one result beat on the output channel (out_valid /
//   out_stall) carrying accepted, rotate, phase_now and the active view.
//   A beat is taken at a clock edge where valid is high and stall is low.
//   A request waits in the input register until the result register is
//   free or its beat is being taken; then the step logic loads the result
//   register and out_valid rises.
//   Throughput is one request per cycle while out_stall stays low; the
//   watchdog state is read and updated in a combinational step.
//   When the receiver stalls, the result register holds its beat and an
//   empty input register takes one more request; after that in_stall rises.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) are
//   always ready and must be issued while no request is in flight.
//   Reset clears the watchdog to inactive with no view and restores the
//   register defaults (1000, 1000, all event codes enabled).
// ----------------------------------------------------------------------------
module leader_progress_watchdog
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lpw_pkg::OP_W-1:0]       operation,
    input  logic [lpw_pkg::GEN_W-1:0]      view_gen,
    input  logic [lpw_pkg::TAG_W-1:0]      view_tag,
    input  logic [lpw_pkg::CODE_W-1:0]     event_code,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic                           rotate,
    output logic [1:0]                     phase_now,
    output logic                           active_valid,
    output logic [lpw_pkg::GEN_W-1:0]      active_generation,
    output logic [lpw_pkg::TAG_W-1:0]      active_tag,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpw_pkg::TICKS_W-1:0]    cfg_data
);

    lpw_pkg::cfg_t     cfg_reg;
    lpw_pkg::item_t    item_reg;
    logic              item_valid_reg;
    lpw_pkg::result_t  result_reg;
    logic              out_valid_reg;
    lpw_pkg::result_t  step_res;
    logic              advance;
    logic              in_take;

    // The staged request moves on whenever the result register is free or
    // its beat is being taken this cycle.
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    lpw_engine u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grace_ticks    <= lpw_pkg::GRACE_RESET;
            cfg_reg.progress_ticks <= lpw_pkg::PROGRESS_RESET;
            cfg_reg.event_mask     <= lpw_pkg::MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lpw_pkg::CFG_GRACE_TICKS:    cfg_reg.grace_ticks    <= cfg_data;
                lpw_pkg::CFG_PROGRESS_TICKS: cfg_reg.progress_ticks <= cfg_data;
                lpw_pkg::CFG_EVENT_MASK:
                    cfg_reg.event_mask <= cfg_data[lpw_pkg::MASK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation  <= operation;
            item_reg.view_gen   <= view_gen;
            item_reg.view_tag   <= view_tag;
            item_reg.event_code <= event_code;
        end
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign accepted          = result_reg.accepted;
    assign rotate            = result_reg.rotate;
    assign phase_now         = result_reg.phase_now;
    assign active_valid      = result_reg.active_valid;
    assign active_generation = result_reg.active_generation;
    assign active_tag        = result_reg.active_tag;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the leader progress watchdog.
// A short table of directed requests covers the corner cases; its closing rows
// follow phases of random request streams under changing register settings.
// Each status beat, pinned in the table or predicted by a behavioral watchdog
// model kept in this bench, is compared field by field with the block's beat.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [lpw_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd5;
    localparam logic [lpw_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int LONG_HOLD   = 48;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic                        is_write;
        logic                        pinned;
        lpw_pkg::cfg_index_t         sel;
        logic [lpw_pkg::TICKS_W-1:0] data;
        lpw_pkg::item_t              req;
        lpw_pkg::result_t            want;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [lpw_pkg::OP_W-1:0]      operation;
    logic [lpw_pkg::GEN_W-1:0]     view_gen;
    logic [lpw_pkg::TAG_W-1:0]     view_tag;
    logic [lpw_pkg::CODE_W-1:0]    event_code;
    logic                          out_valid;
    logic                          out_stall;
    logic                          accepted;
    logic                          rotate;
    logic [1:0]                    phase_now;
    logic                          active_valid;
    logic [lpw_pkg::GEN_W-1:0]     active_generation;
    logic [lpw_pkg::TAG_W-1:0]     active_tag;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lpw_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lpw_pkg::TICKS_W-1:0]   cfg_data;

    // Watchdog model state and its copy of the registers.
    logic [lpw_pkg::TICKS_W-1:0] grace_len    = lpw_pkg::GRACE_RESET;
    logic [lpw_pkg::TICKS_W-1:0] progress_len = lpw_pkg::PROGRESS_RESET;
    logic [lpw_pkg::MASK_W-1:0]  code_mask    = lpw_pkg::MASK_RESET;
    logic                        wd_stopped   = 1'b0;
    logic [1:0]                  wd_phase     = lpw_pkg::PH_CODE_INACTIVE;
    logic                        view_live    = 1'b0;
    logic [lpw_pkg::GEN_W-1:0]   live_gen     = '0;
    logic [lpw_pkg::TAG_W-1:0]   live_tag     = '0;
    logic [lpw_pkg::GEN_W-1:0]   top_gen      = '0;
    logic [lpw_pkg::COUNT_W-1:0] ticks_left   = '0;
    logic                        grant_used   = 1'b0;

    lpw_pkg::result_t status_due[$];
    plan_row_t        plan[$];

    bit src_gaps;
    bit sink_gaps;
    bit hold_req;
    int fail_count;
    int requests_sent;
    int beats_checked;
    int beats_accepted;
    int rotations_seen;
    int writes_done;
    int quiet_cycles;

    leader_progress_watchdog uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic names_live(input lpw_pkg::item_t rq);
        return view_live && rq.view_gen == live_gen && rq.view_tag == live_tag;
    endfunction

    function automatic lpw_pkg::result_t step_watchdog(input lpw_pkg::item_t rq);
        lpw_pkg::result_t r;
        logic             live;
        r = '0;
        if (!wd_stopped)
        begin
            case (rq.operation)
                lpw_pkg::OP_ACTIVATE:
                    if (rq.view_gen != '0 && rq.view_gen > top_gen)
                    begin
                        top_gen    = rq.view_gen;
                        view_live  = 1'b1;
                        live_gen   = rq.view_gen;
                        live_tag   = rq.view_tag;
                        wd_phase   = lpw_pkg::PH_CODE_GRACE;
                        ticks_left = {1'b0, grace_len};
                        grant_used = 1'b0;
                        r.accepted = 1'b1;
                    end
                lpw_pkg::OP_PROGRESS:
                    if (names_live(rq) && code_mask[rq.event_code])
                    begin
                        if (wd_phase == lpw_pkg::PH_CODE_GRACE)
                        begin
                            r.accepted = 1'b1;
                        end
                        else if (wd_phase == lpw_pkg::PH_CODE_PROGRESS)
                        begin
                            ticks_left = {1'b0, progress_len};
                            r.accepted = 1'b1;
                        end
                    end
                lpw_pkg::OP_GRANT:
                    if (names_live(rq) && !grant_used &&
                        (wd_phase == lpw_pkg::PH_CODE_GRACE ||
                         wd_phase == lpw_pkg::PH_CODE_PROGRESS))
                    begin
                        // Twice the progress count, which always fits the wider counter.
                        ticks_left = {progress_len, 1'b0};
                        wd_phase   = lpw_pkg::PH_CODE_PROGRESS;
                        grant_used = 1'b1;
                        r.accepted = 1'b1;
                    end
                lpw_pkg::OP_TICK:
                    if (wd_phase == lpw_pkg::PH_CODE_GRACE ||
                        wd_phase == lpw_pkg::PH_CODE_PROGRESS)
                    begin
                        if (ticks_left != '0)
                            ticks_left = ticks_left - 1'b1;
                        if (ticks_left == '0)
                        begin
                            r.accepted = 1'b1;
                            if (wd_phase == lpw_pkg::PH_CODE_GRACE)
                            begin
                                wd_phase   = lpw_pkg::PH_CODE_PROGRESS;
                                ticks_left = {1'b0, progress_len};
                            end
                            else
                            begin
                                wd_phase = lpw_pkg::PH_CODE_EXPIRED;
                                r.rotate = 1'b1;
                            end
                        end
                    end
                lpw_pkg::OP_SHUTDOWN:
                begin
                    wd_stopped = 1'b1;
                    view_live  = 1'b0;
                    live_gen   = '0;
                    live_tag   = '0;
                    wd_phase   = lpw_pkg::PH_CODE_INACTIVE;
                    ticks_left = '0;
                    r.accepted = 1'b1;
                end
                default: ;
            endcase
        end
        live                = view_live && !wd_stopped;
        r.phase_now         = wd_stopped ? lpw_pkg::PH_CODE_INACTIVE : wd_phase;
        r.active_valid      = live;
        r.active_generation = live ? live_gen : '0;
        r.active_tag        = live ? live_tag : '0;
        return r;
    endfunction

    function automatic lpw_pkg::result_t status(input logic acc, input logic rot,
                                                input logic [1:0] ph, input logic av,
                                                input logic [lpw_pkg::GEN_W-1:0] gen,
                                                input logic [lpw_pkg::TAG_W-1:0] tag);
        return {acc, rot, ph, av, gen, tag};
    endfunction

    function automatic void req_row(input logic [lpw_pkg::OP_W-1:0] op,
                                    input logic [lpw_pkg::GEN_W-1:0] gen,
                                    input logic [lpw_pkg::TAG_W-1:0] tag,
                                    input logic [lpw_pkg::CODE_W-1:0] code);
        plan_row_t row;
        row     = '0;
        row.req = {op, gen, tag, code};
        plan.push_back(row);
    endfunction

    function automatic void pin_row(input logic [lpw_pkg::OP_W-1:0] op,
                                    input logic [lpw_pkg::GEN_W-1:0] gen,
                                    input logic [lpw_pkg::TAG_W-1:0] tag,
                                    input logic [lpw_pkg::CODE_W-1:0] code,
                                    input lpw_pkg::result_t want);
        plan_row_t row;
        row        = '0;
        row.pinned = 1'b1;
        row.req    = {op, gen, tag, code};
        row.want   = want;
        plan.push_back(row);
    endfunction

    function automatic void cfg_row(input lpw_pkg::cfg_index_t sel,
                                    input logic [lpw_pkg::TICKS_W-1:0] value);
        plan_row_t row;
        row          = '0;
        row.is_write = 1'b1;
        row.sel      = sel;
        row.data     = value;
        plan.push_back(row);
    endfunction

    // Mostly well-formed traffic for the live view, with stale and foreign
    // views, undefined codes and bare ticks mixed in.
    function automatic lpw_pkg::item_t pick_request();
        lpw_pkg::item_t rq;
        int             roll;
        rq.operation  = lpw_pkg::OP_TICK;
        rq.view_gen   = $urandom;
        rq.view_tag   = 16'($urandom_range(0, 16'hFFFF));
        rq.event_code = 3'($urandom_range(0, 7));
        roll          = $urandom_range(0, 99);
        if ((!view_live || wd_phase == lpw_pkg::PH_CODE_EXPIRED) && $urandom_range(0, 99) < 50)
            roll = 0;
        if (roll < 8)
        begin
            rq.operation = lpw_pkg::OP_ACTIVATE;
            rq.view_gen  = top_gen + $urandom_range(1, 1 << 21);
        end
        else if (roll < 11)
        begin
            rq.operation = lpw_pkg::OP_ACTIVATE;
            rq.view_gen  = $urandom_range(0, top_gen);
        end
        else if (roll < 50)
        begin
            rq.operation = lpw_pkg::OP_TICK;
        end
        else if (roll < 81)
        begin
            rq.operation = (roll < 76) ? lpw_pkg::OP_PROGRESS : lpw_pkg::OP_GRANT;
            rq.view_gen  = live_gen;
            rq.view_tag  = live_tag;
        end
        else if (roll < 91)
        begin
            rq.operation = $urandom_range(0, 1) ? lpw_pkg::OP_PROGRESS : lpw_pkg::OP_GRANT;
            rq.view_gen  = live_gen;
            rq.view_tag  = live_tag;
            if ($urandom_range(0, 1))
                rq.view_gen ^= 32'd1 << $urandom_range(0, lpw_pkg::GEN_W - 1);
            else
                rq.view_tag ^= 16'd1 << $urandom_range(0, lpw_pkg::TAG_W - 1);
        end
        else
        begin
            rq.operation = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic push_request(input lpw_pkg::item_t rq, input logic pinned,
                                input lpw_pkg::result_t want);
        lpw_pkg::result_t got;
        if (src_gaps && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= rq.operation;
        view_gen   <= rq.view_gen;
        view_tag   <= rq.view_tag;
        event_code <= rq.event_code;
        do @(posedge clk); while (in_stall);
        got = step_watchdog(rq);
        status_due.push_back(pinned ? want : got);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input lpw_pkg::cfg_index_t sel,
                             input logic [lpw_pkg::TICKS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (sel)
            lpw_pkg::CFG_GRACE_TICKS:    grace_len    = value;
            lpw_pkg::CFG_PROGRESS_TICKS: progress_len = value;
            lpw_pkg::CFG_EVENT_MASK:     code_mask    = value[lpw_pkg::MASK_W-1:0];
            default: ;
        endcase
        writes_done++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic play_row(input plan_row_t row);
        if (row.is_write)
        begin
            wait_drained();
            write_reg(row.sel, row.data);
        end
        else
        begin
            push_request(row.req, row.pinned, row.want);
        end
    endtask

    function automatic void note_field(input string name,
                                       input logic [lpw_pkg::GEN_W-1:0] want,
                                       input logic [lpw_pkg::GEN_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : status_check
        lpw_pkg::result_t want;
        lpw_pkg::result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {accepted, rotate, phase_now, active_valid, active_generation, active_tag};
            if (status_due.size() == 0)
            begin
                $display("%0t: status beat with nothing expected: actual %0h", $time, got);
                fail_count++;
            end
            else
            begin
                want = status_due.pop_front();
                note_field("accepted", 32'(want.accepted), 32'(got.accepted));
                note_field("rotate", 32'(want.rotate), 32'(got.rotate));
                note_field("phase_now", 32'(want.phase_now), 32'(got.phase_now));
                note_field("active_valid", 32'(want.active_valid), 32'(got.active_valid));
                note_field("active_generation", want.active_generation,
                           got.active_generation);
                note_field("active_tag", 32'(want.active_tag), 32'(got.active_tag));
                beats_checked++;
                if (got.accepted === 1'b1)
                    beats_accepted++;
                if (got.rotate === 1'b1)
                    rotations_seen++;
            end
        end
    end

    always @(posedge clk)
    begin : stall_watch
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stall bursts, or one long hold on request.
    initial
    begin : result_sink
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (sink_gaps && $urandom_range(0, 99) < 15)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int                          head_rows;
        logic [lpw_pkg::TICKS_W-1:0] grace_set;
        logic [lpw_pkg::TICKS_W-1:0] progress_set;
        logic [lpw_pkg::MASK_W-1:0]  mask_set;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = lpw_pkg::OP_TICK;
        view_gen   = '0;
        view_tag   = '0;
        event_code = '0;
        cfg_valid  = 1'b0;
        cfg_index  = lpw_pkg::CFG_GRACE_TICKS;
        cfg_data   = '0;

        // Opening rows: nothing active yet, then a view under the default counts.
        pin_row(lpw_pkg::OP_TICK, 32'd0, 16'd0, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(lpw_pkg::OP_PROGRESS, 32'hFFFF_FFFF, 16'hFFFF, 3'd7,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(lpw_pkg::OP_ACTIVATE, 32'd0, 16'hFFFF, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(OP_UNDEF_HI, 32'hFFFF_FFFF, 16'hFFFF, 3'd7,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(lpw_pkg::OP_ACTIVATE, 32'd1, 16'd0, 3'd0,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_GRACE, 1'b1, 32'd1, 16'd0));
        pin_row(lpw_pkg::OP_PROGRESS, 32'd1, 16'd0, 3'd7,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_GRACE, 1'b1, 32'd1, 16'd0));
        pin_row(lpw_pkg::OP_PROGRESS, 32'd1, 16'd1, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_GRACE, 1'b1, 32'd1, 16'd0));
        req_row(lpw_pkg::OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 3'd7);
        pin_row(lpw_pkg::OP_GRANT, 32'd1, 16'd0, 3'd0,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_PROGRESS, 1'b1, 32'd1, 16'd0));
        pin_row(lpw_pkg::OP_GRANT, 32'd1, 16'd0, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_PROGRESS, 1'b1, 32'd1, 16'd0));
        pin_row(lpw_pkg::OP_ACTIVATE, 32'd1, 16'd5, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_PROGRESS, 1'b1, 32'd1, 16'd0));
        // Zero grace, one progress tick, only codes 0 and 7 qualify.
        cfg_row(lpw_pkg::CFG_GRACE_TICKS, 32'd0);
        cfg_row(lpw_pkg::CFG_PROGRESS_TICKS, 32'd1);
        cfg_row(lpw_pkg::CFG_EVENT_MASK, 32'h81);
        pin_row(lpw_pkg::OP_ACTIVATE, 32'd2, 16'h1234, 3'd0,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_GRACE, 1'b1, 32'd2, 16'h1234));
        pin_row(lpw_pkg::OP_TICK, 32'd0, 16'd0, 3'd0,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_PROGRESS, 1'b1, 32'd2, 16'h1234));
        pin_row(lpw_pkg::OP_PROGRESS, 32'd2, 16'h1234, 3'd3,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_PROGRESS, 1'b1, 32'd2, 16'h1234));
        pin_row(lpw_pkg::OP_PROGRESS, 32'd2, 16'h1234, 3'd7,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_PROGRESS, 1'b1, 32'd2, 16'h1234));
        pin_row(lpw_pkg::OP_TICK, 32'd0, 16'd0, 3'd0,
                status(1'b1, 1'b1, lpw_pkg::PH_CODE_EXPIRED, 1'b1, 32'd2, 16'h1234));
        req_row(lpw_pkg::OP_GRANT, 32'd2, 16'h1234, 3'd0);
        // Largest counts: the grant window needs the extra counter bit.
        cfg_row(lpw_pkg::CFG_PROGRESS_TICKS, 32'hFFFF_FFFF);
        cfg_row(lpw_pkg::CFG_GRACE_TICKS, 32'hFFFF_FFFF);
        req_row(lpw_pkg::OP_ACTIVATE, 32'd3, 16'hABCD, 3'd0);
        req_row(lpw_pkg::OP_GRANT, 32'd3, 16'hABCD, 3'd0);
        req_row(lpw_pkg::OP_TICK, 32'd0, 16'd0, 3'd0);
        req_row(lpw_pkg::OP_PROGRESS, 32'd3, 16'hABCD, 3'd0);
        head_rows = plan.size();
        // Closing rows: highest generation, then shutdown and the dead block.
        pin_row(lpw_pkg::OP_ACTIVATE, 32'hFFFF_FFFF, 16'hFFFF, 3'd0,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_GRACE, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
        req_row(lpw_pkg::OP_PROGRESS, 32'hFFFF_FFFF, 16'hFFFF, 3'd5);
        req_row(lpw_pkg::OP_GRANT, 32'hFFFF_FFFF, 16'hFFFF, 3'd0);
        pin_row(lpw_pkg::OP_SHUTDOWN, 32'd0, 16'd0, 3'd0,
                status(1'b1, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(lpw_pkg::OP_ACTIVATE, 32'd1, 16'd0, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(lpw_pkg::OP_TICK, 32'd0, 16'd0, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));
        pin_row(lpw_pkg::OP_SHUTDOWN, 32'd0, 16'd0, 3'd0,
                status(1'b0, 1'b0, lpw_pkg::PH_CODE_INACTIVE, 1'b0, 32'd0, 16'd0));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        for (int i = 0; i < head_rows; i++)
            play_row(plan[i]);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin grace_set = 3; progress_set = 4; mask_set = 8'hFF; end
                1: begin grace_set = 0; progress_set = 0; mask_set = 8'h55; end
                2: begin grace_set = 1; progress_set = 1; mask_set = 8'hAA; end
                3:
                begin
                    grace_set    = $urandom_range(0, 12);
                    progress_set = $urandom_range(0, 12);
                    mask_set     = 8'($urandom);
                end
                4:
                begin
                    grace_set    = 32'hFFFF_FFFF;
                    progress_set = 2;
                    mask_set     = 8'($urandom);
                end
                5: begin grace_set = 5; progress_set = 32'hFFFF_FFFF; mask_set = 8'h00; end
                6:
                begin
                    grace_set    = $urandom_range(0, 6);
                    progress_set = $urandom_range(0, 6);
                    mask_set     = 8'($urandom);
                end
                default:
                begin
                    grace_set    = $urandom_range(1, 9);
                    progress_set = $urandom_range(1, 9);
                    mask_set     = 8'($urandom);
                end
            endcase
            wait_drained();
            write_reg(lpw_pkg::CFG_GRACE_TICKS, grace_set);
            write_reg(lpw_pkg::CFG_PROGRESS_TICKS, progress_set);
            write_reg(lpw_pkg::CFG_EVENT_MASK,
                      {{(lpw_pkg::TICKS_W - lpw_pkg::MASK_W){1'b0}}, mask_set});
            // Phase 2 runs back to back, phase 6 backs the block up against a
            // long receiver hold, and the final phase runs without idling.
            src_gaps  = (p != 2 && p != 6 && p != PHASES - 1);
            sink_gaps = (p != 2 && p != PHASES - 1);
            hold_req  = (p == 6);
            repeat (PHASE_ITEMS)
                push_request(pick_request(), 1'b0, '0);
        end

        for (int i = head_rows; i < plan.size(); i++)
            play_row(plan[i]);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("Ran %0d requests through %0d register writes; %0d status beats checked,",
                 requests_sent, writes_done, beats_checked);
        $display("%0d of them accepted and %0d with a rotation.", beats_accepted, rotations_seen);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
